### hw/rtl/colon_key_value_table_lookup_macros.svh
// ----------------------------------------------------------------------------
// colon key/value table lookup assertion macros
// shared property forms for the table lookup checks
// ----------------------------------------------------------------------------
`ifndef COLON_KEY_VALUE_TABLE_LOOKUP_MACROS_SVH
`define COLON_KEY_VALUE_TABLE_LOOKUP_MACROS_SVH

// same-cycle implication
`define CKVTL_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table lookup check failed");

// next-cycle implication
`define CKVTL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("table lookup check failed");

`endif

### hw/rtl/ckvtl_pkg.sv
// ----------------------------------------------------------------------------
// ckvtl_pkg
// types and constants shared by the table lookup modules
// ----------------------------------------------------------------------------
`default_nettype none

package ckvtl_pkg;

    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;
    localparam int CPOS_W  = 4;
    localparam int KLEN_W  = 5;
    localparam int VLEN_W  = 4;
    localparam int VAL_BITS = 80;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] COLON_CHAR   = 8'd58;
    localparam logic [7:0] ZERO_CHAR    = 8'd0;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              key_we;
        logic [CPOS_W-1:0] key_pos;
        logic [7:0]        key_data;
        logic              val_we;
        logic [CPOS_W-1:0] val_pos;
        logic [7:0]        val_data;
        logic              len_we;
        logic [KLEN_W-1:0] key_len;
        logic [VLEN_W-1:0] val_len;
    } wr_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CPOS_W-1:0] pos;
    } rd_req_t;

    typedef struct packed {
        logic [7:0]        key_data;
        logic [7:0]        val_data;
        logic [KLEN_W-1:0] key_len;
        logic [VLEN_W-1:0] val_len;
    } rd_data_t;

endpackage

`default_nettype wire

### hw/rtl/ckvtl_load.sv
// ----------------------------------------------------------------------------
// ckvtl_load
// splits load text into key/value lines and issues table writes
// ----------------------------------------------------------------------------
`default_nettype none

module ckvtl_load #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_CHARS   = 10,
    parameter int VALUE_CHARS = 10,
    parameter int LINE_LIMIT  = 100
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load_en,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       end_of_stream,
    output ckvtl_pkg::wr_t                  wr,
    output logic [ckvtl_pkg::CNT_W-1:0]     entry_count
);

    localparam int LPW = $clog2(LINE_LIMIT);
    localparam int KLW = ckvtl_pkg::KLEN_W;
    localparam int VLW = ckvtl_pkg::VLEN_W;
    localparam int CW  = ckvtl_pkg::CNT_W;
    localparam int SW  = ckvtl_pkg::SLOT_W;
    localparam int PW  = ckvtl_pkg::CPOS_W;
    localparam logic [KLW-1:0] KC  = KLW'(KEY_CHARS);
    localparam logic [VLW-1:0] VC  = VLW'(VALUE_CHARS);
    localparam logic [CW-1:0]  TD  = CW'(TABLE_DEPTH);
    localparam logic [LPW-1:0] LLM = LPW'(LINE_LIMIT - 1);

    logic [LPW-1:0] pos_reg, pos_next;
    logic           colon_reg, colon_next;
    logic           dead_reg, dead_next;
    logic [KLW-1:0] pkl_reg, pkl_next;
    logic [VLW-1:0] pvl_reg, pvl_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           slot_ok;
    logic           fin;

    assign slot_ok     = cnt_reg < TD;
    assign entry_count = cnt_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        colon_next = colon_reg;
        dead_next  = dead_reg;
        pkl_next   = pkl_reg;
        pvl_next   = pvl_reg;
        cnt_next   = cnt_reg;
        fin        = 1'b0;
        wr         = '0;
        wr.slot    = cnt_reg[SW-1:0];
        wr.key_pos = PW'(pkl_reg);
        wr.val_pos = PW'(pvl_reg);
        wr.key_data = data_byte;
        wr.val_data = data_byte;
        if (load_en)
        begin
            if (data_byte == ckvtl_pkg::NEWLINE_CHAR)
            begin
                fin = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (!dead_reg)
                begin
                    if (data_byte == ckvtl_pkg::ZERO_CHAR)
                    begin
                        dead_next = 1'b1;
                    end
                    else if (data_byte == ckvtl_pkg::COLON_CHAR && !colon_reg)
                    begin
                        colon_next = 1'b1;
                    end
                    else if (colon_reg)
                    begin
                        wr.val_we = slot_ok && (pvl_reg < VC);
                        if (pvl_reg <= VC)
                        begin
                            pvl_next = pvl_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        wr.key_we = slot_ok && (pkl_reg < KC);
                        if (pkl_reg <= KC)
                        begin
                            pkl_next = pkl_reg + 1'b1;
                        end
                    end
                end
                if (end_of_stream || pos_next >= LLM)
                begin
                    fin = 1'b1;
                end
            end
            if (fin)
            begin
                wr.key_len = pkl_next;
                wr.val_len = pvl_next;
                if (colon_next && pkl_next != '0 && pkl_next <= KC &&
                    pvl_next != '0 && pvl_next <= VC && slot_ok)
                begin
                    wr.len_we = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                pos_next   = '0;
                colon_next = 1'b0;
                dead_next  = 1'b0;
                pkl_next   = '0;
                pvl_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            colon_reg <= 1'b0;
            dead_reg  <= 1'b0;
            pkl_reg   <= '0;
            pvl_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            colon_reg <= colon_next;
            dead_reg  <= dead_next;
            pkl_reg   <= pkl_next;
            pvl_reg   <= pvl_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ckvtl_store.sv
// ----------------------------------------------------------------------------
// ckvtl_store
// key, value and length memories with one write and one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ckvtl_store #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_CHARS   = 10,
    parameter int VALUE_CHARS = 10
) (
    input  wire logic               clk,
    input  wire ckvtl_pkg::wr_t     wr,
    input  wire ckvtl_pkg::rd_req_t rd_req,
    output ckvtl_pkg::rd_data_t     rd_data
);

    localparam int SW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KPW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int VPW = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1;
    localparam int LW  = ckvtl_pkg::KLEN_W + ckvtl_pkg::VLEN_W;

    logic [7:0]    key_mem [TABLE_DEPTH * (2 ** KPW)];
    logic [7:0]    val_mem [TABLE_DEPTH * (2 ** VPW)];
    logic [LW-1:0] len_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[{wr.slot[SW-1:0], wr.key_pos[KPW-1:0]}] <= wr.key_data;
        end
        if (wr.val_we)
        begin
            val_mem[{wr.slot[SW-1:0], wr.val_pos[VPW-1:0]}] <= wr.val_data;
        end
        if (wr.len_we)
        begin
            len_mem[wr.slot[SW-1:0]] <= {wr.key_len, wr.val_len};
        end
        rd_data.key_data <= key_mem[{rd_req.slot[SW-1:0], rd_req.pos[KPW-1:0]}];
        rd_data.val_data <= val_mem[{rd_req.slot[SW-1:0], rd_req.pos[VPW-1:0]}];
        {rd_data.key_len, rd_data.val_len} <= len_mem[rd_req.slot[SW-1:0]];
    end

endmodule

`default_nettype wire

### hw/rtl/ckvtl_scan.sv
// ----------------------------------------------------------------------------
// ckvtl_scan
// query capture and table scan sequencer with one shared byte compare
// ----------------------------------------------------------------------------
`default_nettype none

module ckvtl_scan #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_CHARS   = 10,
    parameter int VALUE_CHARS = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           query_en,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           end_of_stream,
    input  wire logic [ckvtl_pkg::CNT_W-1:0]    entry_count,
    input  wire ckvtl_pkg::rd_data_t            rd_data,
    output ckvtl_pkg::rd_req_t                  rd_req,
    output logic                                busy,
    output logic                                strobe,
    output logic                                found,
    output logic [5:0]                          entry_index,
    output logic [63:0]                         value_low,
    output logic [15:0]                         value_high,
    output logic [3:0]                          value_length,
    output logic                                last_result
);

    localparam int KPW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int KLW = ckvtl_pkg::KLEN_W;
    localparam int VLW = ckvtl_pkg::VLEN_W;
    localparam int CW  = ckvtl_pkg::CNT_W;
    localparam int SW  = ckvtl_pkg::SLOT_W;
    localparam int PW  = ckvtl_pkg::CPOS_W;
    localparam int VB  = ckvtl_pkg::VAL_BITS;
    localparam logic [KLW-1:0] KC = KLW'(KEY_CHARS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LEN  = 8'b0000_0010,
        S_LCHK = 8'b0000_0100,
        S_KRD  = 8'b0000_1000,
        S_KCMP = 8'b0001_0000,
        S_VRD  = 8'b0010_0000,
        S_VCAP = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [7:0]      qchars_reg [KEY_CHARS];
    logic [KLW-1:0]  qlen_reg, qlen_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [VLW-1:0]  vlen_reg, vlen_next;
    logic [VB-1:0]   vbytes_reg, vbytes_next;
    logic            pv_valid_reg, pv_valid_next;
    logic [SW-1:0]   pv_slot_reg, pv_slot_next;
    logic [VB-1:0]   pv_bytes_reg, pv_bytes_next;
    logic [VLW-1:0]  pv_len_reg, pv_len_next;
    logic            strobe_reg, strobe_next;
    logic            found_reg, found_next;
    logic [5:0]      index_reg, index_next;
    logic [VB-1:0]   val_reg, val_next;
    logic [3:0]      vl_reg, vl_next;
    logic            last_reg, last_next;
    logic            slot_end;
    logic            qwrite;

    assign slot_end = (CW'(slot_reg) + 1'b1) == entry_count;
    assign qwrite   = (state_reg == S_IDLE) && query_en && (qlen_reg < KC);
    assign rd_req.slot = slot_reg;
    assign rd_req.pos  = pos_reg;

    always_comb
    begin
        state_next    = state_reg;
        qlen_next     = qlen_reg;
        slot_next     = slot_reg;
        pos_next      = pos_reg;
        vlen_next     = vlen_reg;
        vbytes_next   = vbytes_reg;
        pv_valid_next = pv_valid_reg;
        pv_slot_next  = pv_slot_reg;
        pv_bytes_next = pv_bytes_reg;
        pv_len_next   = pv_len_reg;
        strobe_next   = 1'b0;
        found_next    = found_reg;
        index_next    = index_reg;
        val_next      = val_reg;
        vl_next       = vl_reg;
        last_next     = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (query_en)
                begin
                    if (qlen_reg <= KC)
                    begin
                        qlen_next = qlen_reg + 1'b1;
                    end
                    if (end_of_stream)
                    begin
                        slot_next     = '0;
                        pv_valid_next = 1'b0;
                        state_next    = (entry_count == '0) ? S_DONE : S_LEN;
                    end
                end
            end
            S_LEN:
            begin
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                vlen_next = rd_data.val_len;
                pos_next  = '0;
                if (rd_data.key_len == qlen_reg)
                begin
                    state_next = S_KRD;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = slot_end ? S_DONE : S_LEN;
                end
            end
            S_KRD:
            begin
                state_next = S_KCMP;
            end
            S_KCMP:
            begin
                if (rd_data.key_data != qchars_reg[pos_reg[KPW-1:0]])
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = slot_end ? S_DONE : S_LEN;
                end
                else if ((KLW'(pos_reg) + 1'b1) == qlen_reg)
                begin
                    pos_next    = '0;
                    vbytes_next = '0;
                    state_next  = S_VRD;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_KRD;
                end
            end
            S_VRD:
            begin
                state_next = S_VCAP;
            end
            S_VCAP:
            begin
                vbytes_next[pos_reg*8 +: 8] = rd_data.val_data;
                if ((pos_reg + 1'b1) == PW'(vlen_reg))
                begin
                    // hand the held match out, this one waits for the next
                    if (pv_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        found_next  = 1'b1;
                        index_next  = 6'(pv_slot_reg);
                        val_next    = pv_bytes_reg;
                        vl_next     = 4'(pv_len_reg);
                        last_next   = 1'b0;
                    end
                    pv_valid_next = 1'b1;
                    pv_slot_next  = slot_reg;
                    pv_bytes_next = vbytes_next;
                    pv_len_next   = vlen_reg;
                    slot_next     = slot_reg + 1'b1;
                    state_next    = slot_end ? S_DONE : S_LEN;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_VRD;
                end
            end
            S_DONE:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                found_next  = pv_valid_reg;
                index_next  = pv_valid_reg ? 6'(pv_slot_reg) : 6'd0;
                val_next    = pv_valid_reg ? pv_bytes_reg : '0;
                vl_next     = pv_valid_reg ? 4'(pv_len_reg) : 4'd0;
                qlen_next   = '0;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (qwrite)
        begin
            qchars_reg[qlen_reg[KPW-1:0]] <= data_byte;
        end
        slot_reg     <= slot_next;
        pos_reg      <= pos_next;
        vlen_reg     <= vlen_next;
        vbytes_reg   <= vbytes_next;
        pv_slot_reg  <= pv_slot_next;
        pv_bytes_reg <= pv_bytes_next;
        pv_len_reg   <= pv_len_next;
        found_reg    <= found_next;
        index_reg    <= index_next;
        val_reg      <= val_next;
        vl_reg       <= vl_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            qlen_reg     <= '0;
            pv_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            qlen_reg     <= qlen_next;
            pv_valid_reg <= pv_valid_next;
            strobe_reg   <= strobe_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = strobe_reg;
    assign found        = found_reg;
    assign entry_index  = index_reg;
    assign value_low    = val_reg[63:0];
    assign value_high   = val_reg[79:64];
    assign value_length = vl_reg;
    assign last_result  = last_reg;

endmodule

`default_nettype wire

### hw/rtl/colon_key_value_table_lookup.sv
// ----------------------------------------------------------------------------
// colon_key_value_table_lookup
// key/value table loaded from colon-separated text lines, searched by key
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Load text words and
// query words that do not end a query leave busy low. The last query word
// starts a scan of the table, one entry at a time through a single byte
// compare: a length check per entry, then on a length match a compare per
// key byte and, on a key match, a read per value byte, all from the table
// memories' one read port. Results appear on strobe for one cycle each, in
// table order, the last one marked by last_result; they cannot be held off,
// so the receiver must take each one as it comes.
`default_nettype none

`include "colon_key_value_table_lookup_macros.svh"

module colon_key_value_table_lookup #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_CHARS   = 10,
    parameter int VALUE_CHARS = 10,
    parameter int LINE_LIMIT  = 100
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_stream,
    output logic             strobe,
    output logic             found,
    output logic [5:0]       entry_index,
    output logic [63:0]      value_low,
    output logic [15:0]      value_high,
    output logic [3:0]       value_length,
    output logic             last_result
);

    ckvtl_pkg::wr_t                 wr;
    ckvtl_pkg::rd_req_t             rd_req;
    ckvtl_pkg::rd_data_t            rd_data;
    logic [ckvtl_pkg::CNT_W-1:0]    entry_count;
    logic                           load_en;
    logic                           query_en;

    assign load_en  = start && !busy && !req_type;
    assign query_en = start && !busy && req_type;

    ckvtl_load #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_CHARS   (KEY_CHARS),
        .VALUE_CHARS (VALUE_CHARS),
        .LINE_LIMIT  (LINE_LIMIT)
    ) u_load (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_en       (load_en),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .wr            (wr),
        .entry_count   (entry_count)
    );

    ckvtl_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_CHARS   (KEY_CHARS),
        .VALUE_CHARS (VALUE_CHARS)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    ckvtl_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_CHARS   (KEY_CHARS),
        .VALUE_CHARS (VALUE_CHARS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .query_en      (query_en),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .entry_count   (entry_count),
        .rd_data       (rd_data),
        .rd_req        (rd_req),
        .busy          (busy),
        .strobe        (strobe),
        .found         (found),
        .entry_index   (entry_index),
        .value_low     (value_low),
        .value_high    (value_high),
        .value_length  (value_length),
        .last_result   (last_result)
    );

    // final result of a query leaves the block free
    `CKVTL_ASSERT_SAME(a_last_frees, strobe && last_result, !busy)
    // earlier results of a query come while the scan still runs
    `CKVTL_ASSERT_SAME(a_more_busy, strobe && !last_result, busy && found)
    // a not-found answer is always the only and last one
    `CKVTL_ASSERT_SAME(a_miss_last, strobe && !found, last_result && value_length == 4'd0)
    // the last query word starts a scan
    `CKVTL_ASSERT_NEXT(a_query_scan, start && !busy && req_type && end_of_stream, busy)

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the colon key/value table lookup. Text lines and query keys are
// sent over the start/busy handshake. A predictor in the bench tracks the
// line parser, the table and the query key, and works out every result of
// a query. The strobed results are compared in order against those
// predictions while sender gaps vary from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH      = 64;
    localparam int KCHARS     = 10;
    localparam int VCHARS     = 10;
    localparam int LINE_MAX   = 100;
    localparam int STALL_STOP = 20000;
    localparam int WORD_GOAL  = 12;

    typedef struct {
        bit        found;
        bit [5:0]  index;
        bit [63:0] low;
        bit [15:0] high;
        bit [3:0]  length;
        bit        last;
    } lookup_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        strobe;
    logic        found;
    logic [5:0]  entry_index;
    logic [63:0] value_low;
    logic [15:0] value_high;
    logic [3:0]  value_length;
    logic        last_result;

    // predicted table and parser
    bit [7:0] tbl_key [DEPTH][KCHARS];
    bit [7:0] tbl_val [DEPTH][VCHARS];
    int       tbl_klen [DEPTH];
    int       tbl_vlen [DEPTH];
    int       tbl_count;
    int       line_pos;
    bit       line_colon;
    int       line_klen;
    int       line_vlen;
    bit       line_dead;
    bit [7:0] qkey [KCHARS];
    int       qkey_len;

    lookup_result_t pending_results[$];
    string          key_pool[$];
    int             fails;
    int             idle_pct;
    int             words_sent;
    int             results_seen;
    int             stall_cycles;

    colon_key_value_table_lookup i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .strobe        (strobe),
        .found         (found),
        .entry_index   (entry_index),
        .value_low     (value_low),
        .value_high    (value_high),
        .value_length  (value_length),
        .last_result   (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void close_line();
        if (line_colon && line_klen >= 1 && line_klen <= KCHARS && line_vlen >= 1
            && line_vlen <= VCHARS && tbl_count < DEPTH)
        begin
            tbl_klen[tbl_count] = line_klen;
            tbl_vlen[tbl_count] = line_vlen;
            tbl_count++;
        end
        line_pos   = 0;
        line_colon = 0;
        line_klen  = 0;
        line_vlen  = 0;
        line_dead  = 0;
    endfunction

    function automatic void predict_word(bit rt, bit [7:0] b, bit eos);
        lookup_result_t r;
        bit             hit;
        int             hits;
        hits = 0;
        if (!rt)
        begin
            if (b == ckvtl_pkg::NEWLINE_CHAR)
            begin
                close_line();
                return;
            end
            line_pos++;
            if (!line_dead)
            begin
                if (b == ckvtl_pkg::ZERO_CHAR)
                    line_dead = 1;
                else if (b == ckvtl_pkg::COLON_CHAR && !line_colon)
                    line_colon = 1;
                else if (line_colon)
                begin
                    if (tbl_count < DEPTH && line_vlen < VCHARS)
                        tbl_val[tbl_count][line_vlen] = b;
                    if (line_vlen <= VCHARS)
                        line_vlen++;
                end
                else
                begin
                    if (tbl_count < DEPTH && line_klen < KCHARS)
                        tbl_key[tbl_count][line_klen] = b;
                    if (line_klen <= KCHARS)
                        line_klen++;
                end
            end
            if (eos || line_pos >= LINE_MAX - 1)
                close_line();
            return;
        end
        if (qkey_len < KCHARS)
            qkey[qkey_len] = b;
        if (qkey_len <= KCHARS)
            qkey_len++;
        if (!eos)
            return;
        for (int s = 0; s < tbl_count; s++)
        begin
            hit = (qkey_len == tbl_klen[s]);
            for (int i = 0; hit && i < qkey_len && i < KCHARS; i++)
                if (qkey[i] != tbl_key[s][i])
                    hit = 0;
            if (hit)
            begin
                r = '{1'b1, s[5:0], 64'd0, 16'd0, tbl_vlen[s][3:0], 1'b0};
                for (int i = 0; i < tbl_vlen[s]; i++)
                    if (i < 8)
                        r.low[8*i +: 8] = tbl_val[s][i];
                    else
                        r.high[8*(i-8) +: 8] = tbl_val[s][i];
                pending_results.push_back(r);
                hits++;
            end
        end
        if (hits == 0)
            pending_results.push_back('{1'b0, 6'd0, 64'd0, 16'd0, 4'd0, 1'b1});
        else
            pending_results[$].last = 1'b1;
        qkey_len = 0;
    endfunction

    task automatic send_word(input bit rt, input bit [7:0] b, input bit eos);
        start         <= 1'b1;
        req_type      <= rt;
        data_byte     <= b;
        end_of_stream <= eos;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predict_word(rt, b, eos);
        words_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s, input bit eos_last);
        for (int i = 0; i < s.len(); i++)
            send_word(1'b0, s[i], eos_last && i == s.len() - 1);
    endtask

    task automatic send_query(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(1'b1, s[i], i == s.len() - 1);
    endtask

    function automatic bit [7:0] value_char();
        bit [7:0] c;
        c = 8'($urandom_range(33, 126));
        return (c == ckvtl_pkg::COLON_CHAR) ? 8'd126 : c;
    endfunction

    task automatic test_line_rules();
        send_text("a:1\n", 0);
        send_text("keyofTENch:valueTENch\n", 0);
        send_text("keyELEVENch:v\n", 0);
        send_text("k:valueELEVEN\n", 0);
        send_text("nocolon\n", 0);
        send_text(":v\n", 0);
        send_text("e:\n", 0);
        send_text("m:x:y\n", 0);
        send_word(1'b0, 8'h7a, 1'b0);
        send_word(1'b0, ckvtl_pkg::COLON_CHAR, 1'b0);
        send_word(1'b0, ckvtl_pkg::ZERO_CHAR, 1'b0);
        send_text("zz\n", 0);
        send_text("\n", 0);
        send_text("s:end", 1);
        for (int i = 0; i < 104; i++)
            send_word(1'b0, (i == 1) ? ckvtl_pkg::COLON_CHAR : 8'h6c, 1'b0);
        send_text(":w\n", 0);
    endtask

    task automatic test_query_rules();
        send_query("a");
        send_query("keyofTENch");
        send_query("keyELEVENch");
        send_query("m");
        send_query("s");
        send_query("z");
        send_query("nothere");
        send_word(1'b1, 8'hff, 1'b0);
        send_word(1'b1, ckvtl_pkg::ZERO_CHAR, 1'b0);
        send_word(1'b1, 8'h20, 1'b1);
    endtask

    task automatic test_random_traffic();
        int       n;
        int       stop_at;
        string    k;
        stop_at = words_sent + WORD_GOAL;
        while (words_sent < stop_at)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                begin
                    k = key_pool[$urandom_range(key_pool.size() - 1)];
                    send_text(k, 0);
                    send_word(1'b0, ckvtl_pkg::COLON_CHAR, 1'b0);
                    n = $urandom_range(1, VCHARS);
                    for (int i = 0; i < n; i++)
                        send_word(1'b0, value_char(), 1'b0);
                    send_word(1'b0, ckvtl_pkg::NEWLINE_CHAR, $urandom_range(9) == 0);
                end
                6, 7:
                begin
                    if ($urandom_range(9) < 7)
                        send_query(key_pool[$urandom_range(key_pool.size() - 1)]);
                    else
                    begin
                        n = $urandom_range(1, 12);
                        for (int i = 0; i < n; i++)
                            send_word(1'b1, 8'($urandom_range(255)), i == n - 1);
                    end
                end
                default:
                begin
                    n = $urandom_range(1, 15);
                    for (int i = 0; i < n; i++)
                        send_word(1'b0, 8'($urandom_range(255)), $urandom_range(15) == 0);
                end
            endcase
        end
    endtask

    task automatic test_full_table();
        int extra;
        extra = 0;
        while (tbl_count < DEPTH || extra < 3)
        begin
            if (tbl_count >= DEPTH)
                extra++;
            send_word(1'b0, 8'h64, 1'b0);
            send_word(1'b0, ckvtl_pkg::COLON_CHAR, 1'b0);
            send_word(1'b0, value_char(), 1'b1);
        end
        send_query("d");
    endtask

    always @(posedge clk)
    begin
        lookup_result_t e;
        if (rst_n && strobe)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected");
                fails++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (found !== e.found)
                begin
                    $error("found: expected %0d, got %0d", e.found, found);
                    fails++;
                end
                if (entry_index !== e.index)
                begin
                    $error("entry_index: expected %0d, got %0d", e.index, entry_index);
                    fails++;
                end
                if (value_low !== e.low)
                begin
                    $error("value_low: expected %h, got %h", e.low, value_low);
                    fails++;
                end
                if (value_high !== e.high)
                begin
                    $error("value_high: expected %h, got %h", e.high, value_high);
                    fails++;
                end
                if (value_length !== e.length)
                begin
                    $error("value_length: expected %0d, got %0d", e.length, value_length);
                    fails++;
                end
                if (last_result !== e.last)
                begin
                    $error("last_result: expected %0d, got %0d", e.last, last_result);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_STOP)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        string k;
        fails         = 0;
        words_sent    = 0;
        results_seen  = 0;
        stall_cycles  = 0;
        idle_pct      = 8;
        tbl_count     = 0;
        qkey_len      = 0;
        close_line();
        rst_n         <= 1'b0;
        start         <= 1'b0;
        req_type      <= 1'b0;
        data_byte     <= 8'd0;
        end_of_stream <= 1'b0;
        for (int p = 0; p < 6; p++)
        begin
            k = "";
            repeat ($urandom_range(1, KCHARS + 1))
                k = {k, string'(8'(8'h61 + $urandom_range(2)))};
            key_pool.push_back(k);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_line_rules();
        test_query_rules();
        test_random_traffic();
        idle_pct = 77;
        test_random_traffic();
        test_full_table();
        idle_pct = 0;
        test_random_traffic();
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
